// ===== design/differential_motor_mix_drive_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the differential motor mix drive
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_MOTOR_MIX_DRIVE_DEFINES_SVH
`define DIFFERENTIAL_MOTOR_MIX_DRIVE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every edge outside reset
`define DMM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dmm assertion failed");

// Check a property on every edge, reset included
`define DMM_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("dmm assertion failed");

`else

`define DMM_ASSERT(name, clk, rst, prop)
`define DMM_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== design/dmm_pkg.sv =====
// ---------------------------------------------------------------------------
// Differential motor mix drive package
// Configuration register layout, reset values and shared types.
// ---------------------------------------------------------------------------
package dmm_pkg;

   // Default width of each input term
   localparam int DMM_DATA_WIDTH = 16;

   // Configuration port geometry
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register fields widths
   localparam int LIMIT_WIDTH = 15;
   localparam int LOWER_WIDTH = 16;
   localparam int DB_WIDTH    = 15;

   // Register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_STEER_PRIORITY = 3'd0,
      REG_OUT_UPPER      = 3'd1,
      REG_OUT_LOWER      = 3'd2,
      REG_LEFT_DEADBAND  = 3'd3,
      REG_RIGHT_DEADBAND = 3'd4
   } csr_index_type;

   // Reset values
   localparam logic                          RST_STEER_PRIORITY = 1'b0;
   localparam logic [LIMIT_WIDTH-1:0]        RST_OUT_UPPER      = 15'd9000;
   localparam logic signed [LOWER_WIDTH-1:0] RST_OUT_LOWER      = -16'sd9000;
   localparam logic [DB_WIDTH-1:0]           RST_DEADBAND       = 15'd0;

   // Live configuration handed to the datapath
   typedef struct packed {
      logic                          steer_priority;
      logic [LIMIT_WIDTH-1:0]        out_upper;
      logic signed [LOWER_WIDTH-1:0] out_lower;
      logic [DB_WIDTH-1:0]           left_deadband;
      logic [DB_WIDTH-1:0]           right_deadband;
   } cfg_type;

endpackage

// ===== design/dmm_csr.sv =====
// ---------------------------------------------------------------------------
// Configuration registers
// Write-only register bank; indexes beyond the list are ignored.
// ---------------------------------------------------------------------------
module dmm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [dmm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dmm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output dmm_pkg::cfg_type                      cfg
);
   import dmm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the next register image
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_STEER_PRIORITY: cfg_in.steer_priority = csr_wdata[0];
            REG_OUT_UPPER:      cfg_in.out_upper      = csr_wdata[LIMIT_WIDTH-1:0];
            REG_OUT_LOWER:      cfg_in.out_lower      = signed'(csr_wdata[LOWER_WIDTH-1:0]);
            REG_LEFT_DEADBAND:  cfg_in.left_deadband  = csr_wdata[DB_WIDTH-1:0];
            REG_RIGHT_DEADBAND: cfg_in.right_deadband = csr_wdata[DB_WIDTH-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steer_priority <= RST_STEER_PRIORITY;
         cfg_ff.out_upper      <= RST_OUT_UPPER;
         cfg_ff.out_lower      <= RST_OUT_LOWER;
         cfg_ff.left_deadband  <= RST_DEADBAND;
         cfg_ff.right_deadband <= RST_DEADBAND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/dmm_mix.sv =====
// ---------------------------------------------------------------------------
// Mixing pipeline
// Stage 1 forms the base term, stage 2 mixes steering in, stage 3 clamps.
// ---------------------------------------------------------------------------
module dmm_mix #(
   parameter int DATA_WIDTH = dmm_pkg::DMM_DATA_WIDTH,
   parameter int CALC_WIDTH = ((DATA_WIDTH > 16) ? DATA_WIDTH : 16) + 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dmm_pkg::cfg_type             cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DATA_WIDTH-1:0] balance_term,
   input  logic signed [DATA_WIDTH-1:0] speed_term,
   input  logic signed [DATA_WIDTH-1:0] steer_term,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [CALC_WIDTH-1:0] left_value,
   output logic signed [CALC_WIDTH-1:0] right_value
);
   import dmm_pkg::*;

   localparam int W = CALC_WIDTH;

   logic signed [W-1:0] upper;
   logic signed [W-1:0] lower;

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                s1_ready, s2_ready, s3_ready;
   logic signed [W-1:0] base_ff, base_in;
   logic signed [W-1:0] str_ff, str_in;
   logic signed [W-1:0] mix_left_ff, mix_left_in;
   logic signed [W-1:0] mix_right_ff, mix_right_in;
   logic signed [W-1:0] clamp_left_ff, clamp_left_in;
   logic signed [W-1:0] clamp_right_ff, clamp_right_in;
   logic signed [W-1:0] overflow;
   logic signed [W-1:0] half;

   function automatic logic signed [W-1:0] clamp_lim(
      input logic signed [W-1:0] v,
      input logic signed [W-1:0] hi,
      input logic signed [W-1:0] lo
   );
      logic signed [W-1:0] r;
      r = (v > hi) ? hi : v;
      r = (r < lo) ? lo : r;
      return r;
   endfunction

   assign upper = {{(W-LIMIT_WIDTH){1'b0}}, cfg.out_upper};
   assign lower = {{(W-LOWER_WIDTH){cfg.out_lower[LOWER_WIDTH-1]}}, cfg.out_lower};

   // Per-stage ready: a stage moves when empty or when its successor moves
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage 1: base term and widened steering
   assign base_in = {{(W-DATA_WIDTH){balance_term[DATA_WIDTH-1]}}, balance_term}
                  - {{(W-DATA_WIDTH){speed_term[DATA_WIDTH-1]}}, speed_term};
   assign str_in  = {{(W-DATA_WIDTH){steer_term[DATA_WIDTH-1]}}, steer_term};

   // Stage 2: plain sums, or hold the turning wheel at the limit
   assign overflow = base_ff - upper;
   assign half     = overflow >>> 1;

   always_comb begin
      mix_left_in  = base_ff - str_ff;
      mix_right_in = base_ff + str_ff;
      if (cfg.steer_priority && (base_ff > upper)) begin
         if (!str_ff[W-1]) begin
            mix_left_in  = upper - str_ff + half;
            mix_right_in = upper;
         end else begin
            mix_left_in  = upper;
            mix_right_in = upper + str_ff + half;
         end
      end
   end

   // Stage 3: first clamp
   assign clamp_left_in  = clamp_lim(mix_left_ff, upper, lower);
   assign clamp_right_in = clamp_lim(mix_right_ff, upper, lower);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Payload: load only when a beat moves in
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         base_ff <= base_in;
         str_ff  <= str_in;
      end
      if (s2_ready && s1_valid_ff) begin
         mix_left_ff  <= mix_left_in;
         mix_right_ff <= mix_right_in;
      end
      if (s3_ready && s2_valid_ff) begin
         clamp_left_ff  <= clamp_left_in;
         clamp_right_ff <= clamp_right_in;
      end
   end

   assign out_valid   = s3_valid_ff;
   assign left_value  = clamp_left_ff;
   assign right_value = clamp_right_ff;

endmodule

// ===== design/dmm_shape.sv =====
// ---------------------------------------------------------------------------
// Dead-zone and duty split pipeline
// Stage 4 adds the dead-zone offset and clamps, stage 5 splits into duties.
// ---------------------------------------------------------------------------
`include "differential_motor_mix_drive_defines.svh"

module dmm_shape #(
   parameter int DATA_WIDTH = dmm_pkg::DMM_DATA_WIDTH,
   parameter int CALC_WIDTH = ((DATA_WIDTH > 16) ? DATA_WIDTH : 16) + 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dmm_pkg::cfg_type             cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [CALC_WIDTH-1:0] left_value,
   input  logic signed [CALC_WIDTH-1:0] right_value,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [DATA_WIDTH-2:0]        left_fwd_duty,
   output logic [DATA_WIDTH-2:0]        left_rev_duty,
   output logic [DATA_WIDTH-2:0]        right_fwd_duty,
   output logic [DATA_WIDTH-2:0]        right_rev_duty
);
   import dmm_pkg::*;

   localparam int W = CALC_WIDTH;
   localparam int DUTY_WIDTH = DATA_WIDTH - 1;
   localparam logic signed [W-1:0] MAX_DUTY = W'((2 ** DUTY_WIDTH) - 1);

   logic signed [W-1:0] upper;
   logic signed [W-1:0] lower;
   logic signed [W-1:0] left_db;
   logic signed [W-1:0] right_db;

   logic                  s4_valid_ff, s5_valid_ff;
   logic                  s4_ready, s5_ready;
   logic signed [W-1:0]   dz_left_ff, dz_left_in;
   logic signed [W-1:0]   dz_right_ff, dz_right_in;
   logic [DUTY_WIDTH-1:0] lf_ff, lf_in, lr_ff, lr_in;
   logic [DUTY_WIDTH-1:0] rf_ff, rf_in, rr_ff, rr_in;

   function automatic logic signed [W-1:0] clamp_lim(
      input logic signed [W-1:0] v,
      input logic signed [W-1:0] hi,
      input logic signed [W-1:0] lo
   );
      logic signed [W-1:0] r;
      r = (v > hi) ? hi : v;
      r = (r < lo) ? lo : r;
      return r;
   endfunction

   // Push a non-zero value away from zero by the offset
   function automatic logic signed [W-1:0] dead_zone(
      input logic signed [W-1:0] v,
      input logic signed [W-1:0] db
   );
      logic signed [W-1:0] r;
      r = v;
      if (v > 0) begin
         r = v + db;
      end else if (v < 0) begin
         r = v - db;
      end
      return r;
   endfunction

   // Magnitude, saturated to the duty range
   function automatic logic [DUTY_WIDTH-1:0] duty_mag(input logic signed [W-1:0] v);
      logic signed [W-1:0] m;
      m = v[W-1] ? -v : v;
      if (m > MAX_DUTY) begin
         m = MAX_DUTY;
      end
      return m[DUTY_WIDTH-1:0];
   endfunction

   assign upper    = {{(W-LIMIT_WIDTH){1'b0}}, cfg.out_upper};
   assign lower    = {{(W-LOWER_WIDTH){cfg.out_lower[LOWER_WIDTH-1]}}, cfg.out_lower};
   assign left_db  = {{(W-DB_WIDTH){1'b0}}, cfg.left_deadband};
   assign right_db = {{(W-DB_WIDTH){1'b0}}, cfg.right_deadband};

   assign s5_ready = !s5_valid_ff || out_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign in_ready = s4_ready;

   // Stage 4: dead-zone offset, then clamp again
   assign dz_left_in  = clamp_lim(dead_zone(left_value, left_db), upper, lower);
   assign dz_right_in = clamp_lim(dead_zone(right_value, right_db), upper, lower);

   // Stage 5: forward duty for positive values, reverse otherwise
   always_comb begin
      lf_in = '0;
      lr_in = '0;
      rf_in = '0;
      rr_in = '0;
      if (dz_left_ff > 0) begin
         lf_in = duty_mag(dz_left_ff);
      end else begin
         lr_in = duty_mag(dz_left_ff);
      end
      if (dz_right_ff > 0) begin
         rf_in = duty_mag(dz_right_ff);
      end else begin
         rr_in = duty_mag(dz_right_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s4_ready) begin
            s4_valid_ff <= in_valid;
         end
         if (s5_ready) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && in_valid) begin
         dz_left_ff  <= dz_left_in;
         dz_right_ff <= dz_right_in;
      end
      if (s5_ready && s4_valid_ff) begin
         lf_ff <= lf_in;
         lr_ff <= lr_in;
         rf_ff <= rf_in;
         rr_ff <= rr_in;
      end
   end

   assign out_valid      = s5_valid_ff;
   assign left_fwd_duty  = lf_ff;
   assign left_rev_duty  = lr_ff;
   assign right_fwd_duty = rf_ff;
   assign right_rev_duty = rr_ff;

   // A stalled stage 4 beat keeps its place and its value
   `DMM_ASSERT(a_s4_hold, clock, reset,
      (s4_valid_ff && !s5_ready) |=> (s4_valid_ff && $stable(dz_left_ff) && $stable(dz_right_ff)))
   // Only one direction of each wheel is driven
   `DMM_ASSERT(a_side_excl, clock, reset,
      s5_valid_ff |-> ((lf_ff == '0 || lr_ff == '0) && (rf_ff == '0 || rr_ff == '0)))
   // Reset empties both stages
   `DMM_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> (!s4_valid_ff && !s5_valid_ff))

endmodule

// ===== design/differential_motor_mix_drive.sv =====
// ---------------------------------------------------------------------------
// Differential motor mix drive
// Mixes balance, speed and steering terms into left/right PWM duties.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per control sample: balance, speed and steering
//   terms. rsp_* returns one beat per request with the forward and reverse
//   duties of each wheel. csr_* writes the mode, the clamp limits and the
//   per-side dead-zone offsets; write it only while no beat is in flight.
//   Pipeline: five register stages (base, mix, clamp, dead zone, split);
//   an accepted beat passes through them in order to reach rsp_tvalid.
//   Throughput: one beat per cycle while rsp_tready is high, set by the
//   pipeline, each stage a few adds or compares deep.
//   Reset clears all valid bits and loads the register reset values.
//   When rsp_tready is low, stages fill one by one and bubbles collapse;
//   req_tready drops only when all five stages hold a beat.
// ---------------------------------------------------------------------------
module differential_motor_mix_drive #(
   parameter int DATA_WIDTH = dmm_pkg::DMM_DATA_WIDTH
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // Configuration write port
   input  logic                                        csr_we,
   input  logic [dmm_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [dmm_pkg::CSR_DATA_WIDTH-1:0]          csr_wdata,
   // Request stream
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // balance_term, speed_term, steer_term from bit 0 up; zero padded
   input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]           req_tdata,
   // Response stream
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty from bit 0
   output logic [((4*(DATA_WIDTH-1)+7)/8)*8-1:0]       rsp_tdata
);
   import dmm_pkg::*;

   localparam int CALC_WIDTH = ((DATA_WIDTH > 16) ? DATA_WIDTH : 16) + 3;
   localparam int RSP_WIDTH  = ((4*(DATA_WIDTH-1)+7)/8)*8;

   cfg_type                     cfg;
   logic signed [DATA_WIDTH-1:0] balance_term, speed_term, steer_term;
   logic                        mid_valid, mid_ready;
   logic signed [CALC_WIDTH-1:0] mid_left, mid_right;
   logic [DATA_WIDTH-2:0]       left_fwd_duty, left_rev_duty;
   logic [DATA_WIDTH-2:0]       right_fwd_duty, right_rev_duty;

   // Unpack the request beat
   assign balance_term = signed'(req_tdata[DATA_WIDTH-1:0]);
   assign speed_term   = signed'(req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
   assign steer_term   = signed'(req_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]);

   dmm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dmm_mix #(
      .DATA_WIDTH (DATA_WIDTH),
      .CALC_WIDTH (CALC_WIDTH)
   ) u_mix (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .balance_term (balance_term),
      .speed_term   (speed_term),
      .steer_term   (steer_term),
      .out_valid    (mid_valid),
      .out_ready    (mid_ready),
      .left_value   (mid_left),
      .right_value  (mid_right)
   );

   dmm_shape #(
      .DATA_WIDTH (DATA_WIDTH),
      .CALC_WIDTH (CALC_WIDTH)
   ) u_shape (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (mid_valid),
      .in_ready       (mid_ready),
      .left_value     (mid_left),
      .right_value    (mid_right),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .left_fwd_duty  (left_fwd_duty),
      .left_rev_duty  (left_rev_duty),
      .right_fwd_duty (right_fwd_duty),
      .right_rev_duty (right_rev_duty)
   );

   // Pack the response beat, zero-extended to whole bytes
   assign rsp_tdata = RSP_WIDTH'({right_rev_duty, right_fwd_duty,
                                  left_rev_duty, left_fwd_duty});

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Differential motor mix drive testbench
// Drives balance, speed and steering beats into the mixer and checks every
// wheel duty beat against its table row or a mixing predictor. Directed
// samples under fixed settings come first, then random phases under extreme
// and random settings, with bursty input and an irregular response stall.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dmm_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 175;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;

   // Duties of one response beat; lf sits in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic [14:0] rr;
      logic [14:0] rf;
      logic [14:0] lr;
      logic [14:0] lf;
   } wheel_duties_type;

   typedef struct {
      int                 cfg_sel;
      logic signed [15:0] bal;
      logic signed [15:0] spd;
      logic signed [15:0] str;
      bit                 known;
      wheel_duties_type   want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_STEER_PRIORITY;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   wheel_duties_type pending_duties[$];
   stim_row_type     directed_rows[$];
   cfg_type          directed_cfgs[5];
   cfg_type          cur_cfg;

   int  mismatches      = 0;
   int  results_checked = 0;
   int  samples_sent    = 0;
   int  settings_used   = 0;
   int  cycle_count     = 0;
   int  burst_left      = 1;
   int  hold_left       = 0;
   int  mode_left       = 0;
   int  stall_pct       = 0;
   bit  hold_request    = 1'b0;

   string field_names[4] = '{"left_fwd_duty", "left_rev_duty",
                             "right_fwd_duty", "right_rev_duty"};

   differential_motor_mix_drive uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // balance_term, speed_term, steer_term from bit 0 up
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty from bit 0 up
      .rsp_tdata  (rsp_tdata)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_duties.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // --- mixing predictor ---------------------------------------------------

   function automatic longint clamp_limits(longint v, cfg_type c);
      longint up;
      longint lo;
      up = longint'(c.out_upper);
      lo = longint'($signed(c.out_lower));
      // lower limit last, so it wins when the limits cross
      if (v > up) v = up;
      if (v < lo) v = lo;
      return v;
   endfunction

   function automatic longint push_dead_zone(longint v, logic [14:0] db, cfg_type c);
      if (v > 0)
         v = v + longint'(db);
      else if (v < 0)
         v = v - longint'(db);
      return clamp_limits(v, c);
   endfunction

   function automatic void split_duty(longint v, output logic [14:0] fwd,
                                      output logic [14:0] rev);
      longint mag;
      mag = (v > 0) ? v : -v;
      if (mag > 32767) mag = 32767;
      fwd = (v > 0) ? mag[14:0] : 15'd0;
      rev = (v > 0) ? 15'd0 : mag[14:0];
   endfunction

   function automatic wheel_duties_type mix_duties(cfg_type c, logic signed [15:0] bal,
                                                   logic signed [15:0] spd,
                                                   logic signed [15:0] str);
      longint up;
      longint base;
      longint half;
      longint lft;
      longint rgt;
      wheel_duties_type d;
      up   = longint'(c.out_upper);
      base = longint'(bal) - longint'(spd);
      if (c.steer_priority && base > up) begin
         // turning side sits at the limit, the other gets half the overflow
         half = (base - up) / 2;
         if (str >= 0) begin
            lft = up - longint'(str) + half;
            rgt = up;
         end else begin
            lft = up;
            rgt = up + longint'(str) + half;
         end
      end else begin
         lft = base - longint'(str);
         rgt = base + longint'(str);
      end
      lft = push_dead_zone(clamp_limits(lft, c), c.left_deadband, c);
      rgt = push_dead_zone(clamp_limits(rgt, c), c.right_deadband, c);
      split_duty(lft, d.lf, d.lr);
      split_duty(rgt, d.rf, d.rr);
      return d;
   endfunction

   function automatic wheel_duties_type duties(int lf, int lr, int rf, int rr);
      wheel_duties_type d;
      d.lf = lf[14:0];
      d.lr = lr[14:0];
      d.rf = rf[14:0];
      d.rr = rr[14:0];
      return d;
   endfunction

   // --- random settings and terms ------------------------------------------

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.steer_priority = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0:       c.out_upper = 15'd0;
         1:       c.out_upper = 15'd32767;
         2:       c.out_upper = 15'($urandom_range(0, 12000));
         default: c.out_upper = 15'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0:       c.out_lower = 16'sd0;
         1:       c.out_lower = 16'h8000;
         2:       c.out_lower = 16'(-int'($urandom_range(0, 12000)));
         3:       c.out_lower = 16'(-int'($urandom_range(0, 32767)));
         default: c.out_lower = 16'($urandom);   // may cross above the upper limit
      endcase
      case ($urandom_range(0, 3))
         0:       c.left_deadband = 15'd0;
         1:       c.left_deadband = 15'd32767;
         2:       c.left_deadband = 15'($urandom_range(0, 500));
         default: c.left_deadband = 15'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       c.right_deadband = 15'd0;
         1:       c.right_deadband = 15'd32767;
         2:       c.right_deadband = 15'($urandom_range(0, 500));
         default: c.right_deadband = 15'($urandom);
      endcase
      return c;
   endfunction

   // Mostly values near the clamp limits and zero, some anywhere
   function automatic logic signed [15:0] rand_term(longint centre);
      longint v;
      case ($urandom_range(0, 5))
         0, 1: v = longint'($signed(16'($urandom)));
         2:    v = longint'($urandom_range(0, 400)) - 200;
         3: begin
            case ($urandom_range(0, 4))
               0:       v = 32767;
               1:       v = -32768;
               2:       v = 0;
               3:       v = 1;
               default: v = -1;
            endcase
         end
         default: v = centre + longint'($urandom_range(0, 600)) - 300;
      endcase
      if (v > 32767)  v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // --- driving tasks --------------------------------------------------------

   // Drop valid, wait for every duty beat, then let the pipeline settle
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all five registers while the block is idle
   task automatic apply_cfg(cfg_type c);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_STEER_PRIORITY;
      csr_wdata <= {15'($urandom), c.steer_priority};
      @(negedge clock);
      csr_index <= REG_OUT_UPPER;
      csr_wdata <= {1'($urandom), c.out_upper};
      @(negedge clock);
      csr_index <= REG_OUT_LOWER;
      csr_wdata <= c.out_lower;
      @(negedge clock);
      csr_index <= REG_LEFT_DEADBAND;
      csr_wdata <= {1'($urandom), c.left_deadband};
      @(negedge clock);
      csr_index <= REG_RIGHT_DEADBAND;
      csr_wdata <= {1'($urandom), c.right_deadband};
      @(negedge clock);
      csr_we <= 1'b0;
      cur_cfg = c;
      settings_used++;
   endtask

   // Offer one sample beat; bursts end in a random gap
   task automatic offer_sample(logic signed [15:0] bal, logic signed [15:0] spd,
                               logic signed [15:0] str, bit known,
                               wheel_duties_type typed);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {str, spd, bal};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_duties.push_back(known ? typed : mix_duties(cur_cfg, bal, spd, str));
      samples_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic note_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // --- response side --------------------------------------------------------

   // Stall in moods of random length; one long hold on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD - 1;
         rsp_tready  <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 120);
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 20;
               2:       stall_pct = 50;
               default: stall_pct = 80;
            endcase
         end
         mode_left--;
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Compare each duty beat with the oldest prediction
   always @(posedge clock) begin
      wheel_duties_type got;
      wheel_duties_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[59:0];
         if (pending_duties.size() == 0) begin
            note_mismatch($sformatf("duty beat %h with no sample outstanding", got));
         end else begin
            want = pending_duties.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (got[15*i +: 15] !== want[15*i +: 15])
                  note_mismatch($sformatf("result %0d %s got %0d want %0d",
                                          results_checked, field_names[i],
                                          got[15*i +: 15], want[15*i +: 15]));
            end
         end
         results_checked++;
      end
   end

   // --- stimulus -------------------------------------------------------------

   initial begin
      stim_row_type row;
      cfg_type      c;
      int           active_sel;
      longint       centre;

      // reset values, priority mixing, widest limits, crossed limits, all-zero limits
      directed_cfgs[0] = cfg_type'{1'b0, 15'd9000,  -16'sd9000, 15'd0,     15'd0};
      directed_cfgs[1] = cfg_type'{1'b1, 15'd9000,  -16'sd9000, 15'd0,     15'd0};
      directed_cfgs[2] = cfg_type'{1'b1, 15'd32767, 16'h8000,   15'd100,   15'd200};
      directed_cfgs[3] = cfg_type'{1'b0, 15'd50,    16'sd100,   15'd0,     15'd0};
      directed_cfgs[4] = cfg_type'{1'b1, 15'd0,     16'sd0,     15'd32767, 15'd32767};

      // reset settings: zero, saturation both ways, plain sums
      directed_rows.push_back('{0, 0, 0, 0, 1, duties(0, 0, 0, 0)});
      directed_rows.push_back('{0, 32767, -32768, 0, 1, duties(9000, 0, 9000, 0)});
      directed_rows.push_back('{0, -32768, 32767, 0, 1, duties(0, 9000, 0, 9000)});
      directed_rows.push_back('{0, 100, 0, 30, 1, duties(70, 0, 130, 0)});
      directed_rows.push_back('{0, 0, 0, 32767, 1, duties(0, 9000, 9000, 0)});
      directed_rows.push_back('{0, 0, 0, -32768, 1, duties(9000, 0, 0, 9000)});
      // steering priority: both turning sides, odd overflow, base at the limit
      directed_rows.push_back('{1, 12001, 0, 4000, 1, duties(6500, 0, 9000, 0)});
      directed_rows.push_back('{1, 12001, 0, -4000, 1, duties(9000, 0, 6500, 0)});
      directed_rows.push_back('{1, 20000, 0, 1000, 0, duties(0, 0, 0, 0)});
      directed_rows.push_back('{1, 9000, 0, 100, 0, duties(0, 0, 0, 0)});
      directed_rows.push_back('{1, 9001, 0, 0, 0, duties(0, 0, 0, 0)});
      directed_rows.push_back('{1, 32767, -32768, -32768, 0, duties(0, 0, 0, 0)});
      // widest limits with dead zone: duty saturation, zero kept at zero
      directed_rows.push_back('{2, -32768, 32767, 0, 1, duties(0, 32767, 0, 32767)});
      directed_rows.push_back('{2, 1, 0, 0, 1, duties(101, 0, 201, 0)});
      directed_rows.push_back('{2, 0, 0, 0, 1, duties(0, 0, 0, 0)});
      directed_rows.push_back('{2, -1, 0, 0, 1, duties(0, 101, 0, 201)});
      directed_rows.push_back('{2, 0, 0, -1, 0, duties(0, 0, 0, 0)});
      directed_rows.push_back('{2, 32767, -32768, 5, 0, duties(0, 0, 0, 0)});
      // crossed limits: the lower limit wins
      directed_rows.push_back('{3, 0, 0, 0, 0, duties(0, 0, 0, 0)});
      directed_rows.push_back('{3, -500, 0, 0, 0, duties(0, 0, 0, 0)});
      directed_rows.push_back('{3, 1000, 0, -2000, 0, duties(0, 0, 0, 0)});
      // both limits at zero
      directed_rows.push_back('{4, 1000, 0, 0, 1, duties(0, 0, 0, 0)});
      directed_rows.push_back('{4, -1000, 0, 7, 0, duties(0, 0, 0, 0)});

      cur_cfg    = directed_cfgs[0];
      active_sel = 0;

      // hold reset, then release it on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.cfg_sel != active_sel) begin
            apply_cfg(directed_cfgs[row.cfg_sel]);
            active_sel = row.cfg_sel;
         end
         offer_sample(row.bal, row.spd, row.str, row.known, row.want);
      end

      // random phases: widest settings, narrowest settings, then random ones
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0)
            c = cfg_type'{1'b1, 15'd32767, 16'h8000, 15'd32767, 15'd32767};
         else if (ph == 1)
            c = cfg_type'{1'b0, 15'd0, 16'sd0, 15'd0, 15'd0};
         else
            c = random_cfg();
         apply_cfg(c);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // long response hold while samples keep coming
            if (ph == 2 && n == 10) hold_request = 1'b1;
            // sender pause until every duty beat is back
            if (ph == 4 && n == 90) wait_drained();
            centre = ($urandom_range(0, 3) == 0) ? longint'($signed(cur_cfg.out_lower))
                                                 : longint'(cur_cfg.out_upper);
            offer_sample(rand_term(centre), rand_term(0), rand_term(0), 1'b0,
                         duties(0, 0, 0, 0));
         end
      end

      wait_drained();

      $display("Covered %0d sample beats under %0d register settings (directed table,",
               samples_sent, settings_used);
      $display("  extreme, crossed and random limits); %0d duty beats checked, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/dmm_pkg.sv
design/dmm_csr.sv
design/dmm_mix.sv
design/dmm_shape.sv
design/differential_motor_mix_drive.sv
dv/testbench.sv
